// ===== hdl/escaped_frame_encoder_defines.svh =====
// Assertion macros shared by the escaped frame encoder checkers.
`ifndef ESCAPED_FRAME_ENCODER_DEFINES_SVH
`define ESCAPED_FRAME_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define EFE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("escaped_frame_encoder: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define EFE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("escaped_frame_encoder: next-cycle check failed");

`endif

// ===== hdl/efe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escaped frame encoder package
// Command codes, register indexes, constant bytes and the types passed
// between the decode and output stages.
// ----------------------------------------------------------------------------
package efe_pkg;

    localparam int BURST_MAX = 3;
    localparam int IDX_W     = 2;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_DATA  = 2'd1;
    localparam logic [1:0] MODE_END   = 2'd2;

    localparam logic [1:0] NL_NONE  = 2'd0;
    localparam logic [1:0] NL_LF    = 2'd1;

    localparam logic [1:0] REG_START_CHAR   = 2'd0;
    localparam logic [1:0] REG_END_CHAR     = 2'd1;
    localparam logic [1:0] REG_ESCAPE_CHAR  = 2'd2;
    localparam logic [1:0] REG_NEWLINE_MODE = 2'd3;

    localparam logic [7:0] BYTE_LF = 8'h0A;
    localparam logic [7:0] BYTE_CR = 8'h0D;

    localparam logic [7:0] RST_START_CHAR  = 8'd2;
    localparam logic [7:0] RST_END_CHAR    = 8'd3;
    localparam logic [7:0] RST_ESCAPE_CHAR = 8'd27;

    typedef struct packed {
        logic [7:0] start_char;
        logic [7:0] end_char;
        logic [7:0] escape_char;
        logic [1:0] newline_mode;
    } cfg_t;

    // Up to three bytes caused by one request, with the index of the final one.
    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [IDX_W-1:0]          last_idx;
        logic                      err;
    } burst_t;

endpackage

// ===== hdl/efe_cmd_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escaped frame encoder command decode
// Turns one registered request into its burst of output bytes and the
// next value of the in-frame flag.
// ----------------------------------------------------------------------------
module efe_cmd_decode
    import efe_pkg::*;
(
    input  logic [1:0] mode,
    input  logic [7:0] data_byte,
    input  logic       in_frame,
    input  cfg_t       cfg,
    output burst_t     burst,
    output logic       in_frame_next
);

    always_comb
    begin
        burst.bytes    = '0;
        burst.last_idx = '0;
        burst.err      = 1'b1;
        in_frame_next  = in_frame;
        unique case (mode)
            MODE_START:
            begin
                if (!in_frame)
                begin
                    burst.err      = 1'b0;
                    burst.bytes[0] = cfg.start_char;
                    in_frame_next  = 1'b1;
                end
            end
            MODE_DATA:
            begin
                if (in_frame)
                begin
                    burst.err = 1'b0;
                    // A byte matching either special value gets one escape prefix.
                    if ((data_byte == cfg.escape_char) || (data_byte == cfg.end_char))
                    begin
                        burst.bytes[0] = cfg.escape_char;
                        burst.bytes[1] = data_byte;
                        burst.last_idx = 2'd1;
                    end
                    else
                    begin
                        burst.bytes[0] = data_byte;
                    end
                end
            end
            MODE_END:
            begin
                if (in_frame)
                begin
                    burst.err      = 1'b0;
                    burst.bytes[0] = cfg.end_char;
                    in_frame_next  = 1'b0;
                    unique case (cfg.newline_mode)
                        NL_NONE:
                        begin
                            burst.last_idx = 2'd0;
                        end
                        NL_LF:
                        begin
                            burst.bytes[1] = BYTE_LF;
                            burst.last_idx = 2'd1;
                        end
                        default:
                        begin
                            burst.bytes[1] = BYTE_CR;
                            burst.bytes[2] = BYTE_LF;
                            burst.last_idx = 2'd2;
                        end
                    endcase
                end
            end
            default:
            begin
                burst.err = 1'b1;
            end
        endcase
    end

endmodule

// ===== hdl/efe_out_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escaped frame encoder output sequencer
// Holds one burst in the result register and presents its bytes one per
// accepted output request.
// ----------------------------------------------------------------------------
module efe_out_seq
    import efe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  burst_t     burst,
    output logic       free,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       protocol_error,
    output logic       last
);

    logic             busy_reg;
    logic             busy_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    burst_t           burst_reg;
    logic             at_last;
    logic             out_fire;

    assign at_last  = (idx_reg == burst_reg.last_idx);
    assign out_fire = busy_reg && out_ready;
    assign free     = !busy_reg || (out_ready && at_last);

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (out_fire)
        begin
            if (at_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            burst_reg <= burst;
        end
    end

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    out_byte = burst_reg.bytes[0];
            2'd1:    out_byte = burst_reg.bytes[1];
            2'd2:    out_byte = burst_reg.bytes[2];
            default: out_byte = '0;
        endcase
    end

    assign out_valid      = busy_reg;
    assign byte_valid     = !burst_reg.err;
    assign protocol_error = burst_reg.err;
    assign last           = at_last;

endmodule

// ===== hdl/escaped_frame_encoder.sv =====
`timescale 1ns / 1ps
// A request's first byte goes from the input register into the result register,
// which presents it on the output; while busy, the result register holds it back.
// Throughput: one request per cycle when it gives one byte and out_ready is high;
// a request giving more bytes holds the result register, one byte per output request.
// Reset (rst_n low, asynchronous) empties both registers, clears the in-frame
// flag and restores the configuration defaults.
// ----------------------------------------------------------------------------
// Escaped frame encoder
// Byte-stuffing frame encoder with an input register, command decode and a
// result register that streams each burst of bytes.
// ----------------------------------------------------------------------------
module escaped_frame_encoder
    import efe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       protocol_error,
    output logic       last
);

    cfg_t       cfg_reg;
    logic       hold_valid_reg;
    logic       hold_valid_next;
    logic [1:0] hold_mode_reg;
    logic [7:0] hold_data_reg;
    logic       in_frame_reg;
    logic       in_frame_next;
    burst_t     burst;
    logic       free;
    logic       load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_char   <= RST_START_CHAR;
            cfg_reg.end_char     <= RST_END_CHAR;
            cfg_reg.escape_char  <= RST_ESCAPE_CHAR;
            cfg_reg.newline_mode <= NL_NONE;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_START_CHAR:   cfg_reg.start_char   <= cfg_wdata;
                REG_END_CHAR:     cfg_reg.end_char     <= cfg_wdata;
                REG_ESCAPE_CHAR:  cfg_reg.escape_char  <= cfg_wdata;
                REG_NEWLINE_MODE: cfg_reg.newline_mode <= cfg_wdata[1:0];
                default:          cfg_reg.newline_mode <= cfg_reg.newline_mode;
            endcase
        end
    end

    // The held request moves on as soon as the result register can take its burst.
    assign load     = hold_valid_reg && free;
    assign in_ready = !hold_valid_reg || free;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_valid && in_ready)
        begin
            hold_valid_next = 1'b1;
        end
        else if (load)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            in_frame_reg   <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            if (load)
            begin
                in_frame_reg <= in_frame_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_mode_reg <= mode;
            hold_data_reg <= data_byte;
        end
    end

    efe_cmd_decode u_decode (
        .mode          (hold_mode_reg),
        .data_byte     (hold_data_reg),
        .in_frame      (in_frame_reg),
        .cfg           (cfg_reg),
        .burst         (burst),
        .in_frame_next (in_frame_next)
    );

    efe_out_seq u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (load),
        .burst          (burst),
        .free           (free),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .protocol_error (protocol_error),
        .last           (last)
    );

endmodule

// ===== hdl/efe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escaped frame encoder checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "escaped_frame_encoder_defines.svh"

module efe_checker
    import efe_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       protocol_error,
    input logic       last
);

    // An error result stands alone and carries no byte.
    `EFE_ASSERT_SAME(a_err_single, out_valid && protocol_error, last && !byte_valid)
    // Every result that is not an error carries a byte.
    `EFE_ASSERT_SAME(a_ok_has_byte, out_valid && !protocol_error, byte_valid)
    // Once a burst has started, its remaining bytes follow without a gap.
    `EFE_ASSERT_NEXT(a_burst_cont, out_valid && out_ready && !last, out_valid)
    // A stalled result holds its byte.
    `EFE_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_byte))

endmodule

bind escaped_frame_encoder efe_checker u_efe_checker (.*);
